/* sv/assert_macros.svh */
// assertion macros shared by the allocator rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that must hold on every clock edge outside reset
`define CHK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication checked on the following clock edge
`define CHK_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`endif

/* sv/ffba_pkg.sv */
// shared types and constants of the first-fit block allocator
// no dependencies
package ffba_pkg;
  localparam int DefMaxBlocks = 64;
  localparam int EntryBytes = 8;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_FREE    = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_FINISH  = 2'd3
  } kind_t;

  // datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_LOAD   = 3'd1,
    OP_SCAN   = 3'd2,
    OP_CHECK  = 3'd3,
    OP_SHIFT  = 3'd4,
    OP_COMMIT = 3'd5,
    OP_RESTART = 3'd6,
    OP_FINISH = 3'd7
  } op_t;

  typedef struct packed {
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic shift_done;
    logic check_ok;
    logic active;
  } dp_status_t;
endpackage

/* sv/ffba_ctrl.sv */
// controller state machine of the allocator
// depends on ffba_pkg
module ffba_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [1:0]           kind,
  input  ffba_pkg::dp_status_t status,
  output ffba_pkg::dp_cmd_t    cmd,
  output logic                 busy,
  output logic                 done
);
  import ffba_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_CHECK = 6'b000100,
    S_SHIFT = 6'b001000,
    S_COMMIT = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '{op: OP_NONE};
    done = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op = OP_LOAD;
          case (kind_t'(kind))
            KIND_ALLOC, KIND_FREE: begin
              if (status.active) begin
                state_next = S_SCAN;
              end else begin
                state_next = S_DONE;
              end
            end
            KIND_RESTART: begin
              cmd.op = OP_RESTART;
              state_next = S_DONE;
            end
            default: begin
              cmd.op = OP_FINISH;
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (status.scan_done) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.op = OP_CHECK;
        if (status.check_ok) begin
          state_next = S_SHIFT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SHIFT: begin
        cmd.op = OP_SHIFT;
        if (status.shift_done) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.op = OP_COMMIT;
        state_next = S_DONE;
      end
      S_DONE: begin
        done = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
endmodule

/* sv/ffba_dp.sv */
// datapath of the allocator: block table memory, scan and shift
// depends on ffba_pkg
module ffba_dp #(
  parameter int MaxBlocks = ffba_pkg::DefMaxBlocks,
  parameter int CW = $clog2(MaxBlocks + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ffba_pkg::dp_cmd_t    cmd,
  input  logic [1:0]           kind,
  input  logic [30:0]          request_size,
  input  logic [30:0]          block_start,
  input  logic [30:0]          pool_bytes,
  output ffba_pkg::dp_status_t status,
  output logic                 ok,
  output logic [30:0]          alloc_start,
  output logic [CW-1:0]        pending
);
  import ffba_pkg::*;

  localparam int IW = $clog2(MaxBlocks);

  logic [61:0] mem [MaxBlocks];
  logic [61:0] rd;
  logic [IW-1:0] raddr;

  logic [CW-1:0] live_count;
  logic [30:0] high_water;
  logic active;

  logic is_alloc;
  logic [30:0] size, key;
  logic [CW-1:0] k;
  logic rd_valid;
  logic found;
  logic [CW-1:0] pos;
  logic [31:0] last;
  logic [30:0] prev_end;
  logic [30:0] hit_end;
  logic [CW-1:0] sk;
  logic sh_phase;
  logic shift_done;
  logic [30:0] mark;

  // scan stage on the registered read word
  logic [31:0] here, here_end, gap;
  logic gap_fit, hit;
  assign here = {1'b0, rd[61:31]};
  assign here_end = here + {1'b0, rd[30:0]};
  assign gap = here - last;
  assign gap_fit = (here >= last) && (gap >= {1'b0, size});
  assign hit = (rd[61:31] == key);

  logic scan_done;
  assign scan_done = found || (!rd_valid && k >= live_count);

  // capacity check
  logic [33:0] top, mark_g, lim_a;
  logic [32:0] mk;
  always_comb begin
    top = {3'b0, pool_bytes} - 34'd1
          - (34'(live_count) + 34'd1) * 34'(EntryBytes);
    mk = {1'b0, last} + {2'b0, size} - 33'd1;
    mark_g = ({1'b0, mk} < {3'b0, high_water}) ? {3'b0, high_water} : {1'b0, mk};
    lim_a = {3'b0, high_water} + {3'b0, size};
  end
  logic check_ok_c;
  always_comb begin
    if (is_alloc) begin
      if (size == '0 || live_count >= CW'(MaxBlocks)) begin
        check_ok_c = 1'b0;
      end else if (found) begin
        check_ok_c = $signed(top) > $signed(mark_g);
      end else begin
        check_ok_c = $signed(top) > $signed(lim_a);
      end
    end else begin
      check_ok_c = found;
    end
  end

  // read address select
  always_comb begin
    if (cmd.op == OP_SHIFT) begin
      if (is_alloc) begin
        raddr = IW'(sk - CW'(1));
      end else begin
        raddr = IW'(sk + CW'(1));
      end
    end else begin
      raddr = IW'(k);
    end
  end

  // shift: alloc moves entries up from the top, free moves them down
  always_comb begin
    if (is_alloc) begin
      shift_done = (sk <= pos);
    end else begin
      shift_done = (sk + CW'(1) >= live_count);
    end
  end

  always_ff @(posedge clk) begin
    rd <= mem[raddr];
    if (cmd.op == OP_SHIFT && sh_phase && !shift_done) begin
      mem[IW'(sk)] <= rd;
    end
    if (cmd.op == OP_COMMIT && is_alloc) begin
      mem[IW'(pos)] <= {last[30:0], size};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_count <= '0;
      high_water <= '0;
      active <= 1'b0;
      rd_valid <= 1'b0;
      sh_phase <= 1'b0;
    end else begin
      case (cmd.op)
        OP_LOAD, OP_RESTART, OP_FINISH: begin
          is_alloc <= (kind == KIND_ALLOC);
          size <= request_size;
          key <= block_start;
          k <= '0;
          rd_valid <= 1'b0;
          found <= 1'b0;
          pos <= live_count;
          last <= '0;
          prev_end <= '0;
          ok <= 1'b0;
          alloc_start <= '0;
          pending <= '0;
          if (cmd.op == OP_RESTART) begin
            live_count <= '0;
            high_water <= '0;
            active <= 1'b1;
            ok <= 1'b1;
          end
          if (cmd.op == OP_FINISH && active) begin
            pending <= live_count;
            active <= 1'b0;
            ok <= 1'b1;
          end
        end
        OP_SCAN: begin
          rd_valid <= (k < live_count) && !found;
          if (k < live_count) begin
            k <= k + CW'(1);
          end
          if (rd_valid && !found) begin
            if (is_alloc ? gap_fit : hit) begin
              found <= 1'b1;
              pos <= k - CW'(1);
              hit_end <= here_end[30:0] - 31'd1;
            end else begin
              last <= here_end;
              prev_end <= here_end[30:0] - 31'd1;
            end
          end
        end
        OP_CHECK: begin
          sk <= is_alloc ? live_count : pos;
          sh_phase <= 1'b0;
          mark <= mark_g[30:0];
        end
        OP_SHIFT: begin
          sh_phase <= ~sh_phase;
          if (sh_phase) begin
            sk <= is_alloc ? sk - CW'(1) : sk + CW'(1);
          end
        end
        OP_COMMIT: begin
          ok <= 1'b1;
          if (is_alloc) begin
            live_count <= live_count + CW'(1);
            high_water <= mark;
            alloc_start <= last[30:0];
          end else begin
            live_count <= live_count - CW'(1);
            if (hit_end == high_water) begin
              high_water <= (pos == '0) ? '0 : prev_end;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign status.scan_done = scan_done;
  assign status.shift_done = shift_done && !sh_phase;
  assign status.check_ok = check_ok_c;
  assign status.active = active;
endmodule

/* sv/first_fit_block_allocator.sv */
// first-fit block allocator over a configured byte pool; uses ffba_pkg, ffba_ctrl, ffba_dp
// restart, finish and inactive requests strobe done in the cycle after start is taken;
// allocate and free run a serial table scan, a capacity check and, if it passes, a shift
// that moves each entry with a read and a write step; results cannot be stalled by the receiver
// throughput: one request at a time, the next start is taken once busy drops
// reset: synchronous rst clears the table count, mark, active flag and pool size
`include "assert_macros.svh"
module first_fit_block_allocator #(
  parameter int MAX_BLOCKS = ffba_pkg::DefMaxBlocks
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [30:0] cfg_wdata,
  input  logic [1:0]  kind,
  input  logic [30:0] request_size,
  input  logic [30:0] block_start,
  output logic        done,
  output logic        ok,
  output logic [30:0] alloc_start,
  output logic [6:0]  pending_blocks
);
  import ffba_pkg::*;

  localparam int CW = $clog2(MAX_BLOCKS + 1);

  // pool size register, used live by each request
  logic [30:0] pool_bytes;
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_bytes <= '0;
    end else if (cfg_we) begin
      pool_bytes <= cfg_wdata;
    end
  end

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [CW-1:0] pending;

  ffba_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .kind(kind),
    .status(status), .cmd(cmd), .busy(busy), .done(done)
  );

  ffba_dp #(.MaxBlocks(MAX_BLOCKS), .CW(CW)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .kind(kind),
    .request_size(request_size), .block_start(block_start),
    .pool_bytes(pool_bytes), .status(status), .ok(ok),
    .alloc_start(alloc_start), .pending(pending)
  );

  // live count reported on finish, sized to the word
  assign pending_blocks = 7'(pending);

  // a result word is strobed only while the block is busy
  `CHK_ALWAYS(a_done_busy, !done || busy, "result strobe while idle")
  // a word is followed by an idle cycle
  `CHK_NEXT(a_done_idle, done, !busy, "busy after result")
  // a grant only comes with a success
  `CHK_ALWAYS(a_grant_ok, !done || ok || alloc_start == '0, "grant without ok")
endmodule
